[rtl/hst_pkg.sv]
`default_nettype none

package hst_pkg;

    localparam int CMD_W    = 2;
    localparam int HASH_W   = 64;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  entry_total;
    } hst_result_t;

endpackage

`default_nettype wire

[rtl/hst_if.sv]
`default_nettype none

interface hst_req_if
    import hst_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [HASH_W-1:0] device_hash;

    modport source (output valid, output cmd, output device_hash, input ready);
    modport sink   (input valid, input cmd, input device_hash, output ready);
endinterface

interface hst_res_if
    import hst_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  entry_total;

    modport source (output valid, output status, output entry_total, input ready);
    modport sink   (input valid, input status, input entry_total, output ready);
endinterface

`default_nettype wire

[rtl/hst_out_stage.sv]
`default_nettype none

// Result holding register: lets the core take a new item while a result waits.
module hst_out_stage
    import hst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire hst_result_t res,
    output logic             can_load,
    hst_res_if.source        result
);

    logic        valid_reg;
    hst_result_t res_reg;

    assign can_load = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid       = valid_reg;
    assign result.status      = res_reg.status;
    assign result.entry_total = res_reg.entry_total;

endmodule

`default_nettype wire

[rtl/hash_set_table.sv]
// Result path: a zero hash is rejected without touching the table, an empty table skips
//   the search, and otherwise the result waits on the linear search, which reads one stored
//   entry per cycle from the table memory; a remove hit adds a move step before the result.
// Throughput: one item at a time; a new request is accepted only when the sequencer is idle.
// Reset (rst_n, async, active low): count cleared, control idle, result empty.
//   Table contents are not cleared; entries at or above the count are never compared or moved.
`default_nettype none

module hash_set_table
    import hst_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    hst_req_if.sink   request,
    hst_res_if.source result
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Control sequencer codes
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SEARCH  = 3'd1;
    localparam logic [2:0] S_RESOLVE = 3'd2;
    localparam logic [2:0] S_MOVE    = 3'd3;
    localparam logic [2:0] S_FINISH  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;
    logic              hit_reg, hit_next;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [HASH_W-1:0] key_reg, key_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // Table memory: one write and one registered read per cycle
    logic [HASH_W-1:0] mem [CAPACITY];
    logic [HASH_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [HASH_W-1:0] wr_data;

    logic [CNT_W-1:0]  last_idx;
    logic              out_load;
    logic              out_can_load;
    hst_result_t       out_res;
    logic [CNT_W+TOTAL_W-1:0] total_ext;

    assign last_idx = count_reg - CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Accept a new item only when the sequencer is idle
    assign request.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        slot_next     = slot_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        rd_addr       = idx_reg[ADDR_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_data       = key_reg;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    cmd_next  = request.cmd;
                    key_next  = request.device_hash;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    hit_next  = 1'b0;
                    if (request.device_hash == '0)
                    begin
                        // Reject a zero hash without touching the table
                        status_next = ST_INVALID;
                        state_next  = S_FINISH;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_RESOLVE;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // Compare the entry read last cycle while issuing the next read
                if (pend_reg && (rd_data_reg == key_reg))
                begin
                    hit_next   = 1'b1;
                    slot_next  = pend_idx_reg;
                    state_next = S_RESOLVE;
                end
                else if (pend_reg && (CNT_W'(pend_idx_reg) == last_idx))
                begin
                    state_next = S_RESOLVE;
                end
                else if (idx_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            S_RESOLVE:
            begin
                state_next = S_FINISH;
                priority case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_PRESENT;
                        end
                        else if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // Append at the slot given by the count
                            wr_en       = 1'b1;
                            wr_addr     = count_reg[ADDR_W-1:0];
                            wr_data     = key_reg;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_OK;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            // Fetch the last entry to fill the freed slot
                            rd_addr    = last_idx[ADDR_W-1:0];
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            status_next = ST_MISSING;
                        end
                    end
                    default:
                    begin
                        status_next = hit_reg ? ST_OK : ST_MISSING;
                    end
                endcase
            end

            S_MOVE:
            begin
                wr_en       = 1'b1;
                wr_addr     = slot_reg;
                wr_data     = rd_data_reg;
                count_next  = last_idx;
                status_next = ST_OK;
                state_next  = S_FINISH;
            end

            S_FINISH:
            begin
                // Hold until the result register has room
                if (out_can_load)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
    end

    // Report the low seven bits of the count
    assign total_ext           = {{TOTAL_W{1'b0}}, count_reg};
    assign out_res.status      = status_reg;
    assign out_res.entry_total = total_ext[TOTAL_W-1:0];

    hst_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .res      (out_res),
        .can_load (out_can_load),
        .result   (result)
    );

endmodule

`default_nettype wire

[rtl/hst_checker.sv]
`default_nettype none

module hst_checker
    import hst_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [STATUS_W-1:0] out_status,
    input wire logic [TOTAL_W-1:0]  out_entry_total
);

    localparam int CAP_TOT = (CAPACITY > 127) ? 127 : CAPACITY;

    // One item at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while an item is in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status <= ST_FULL))
        else $error("result status out of range");

    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_status == ST_FULL)) |-> (out_entry_total == TOTAL_W'(CAPACITY)))
        else $error("table full reported below capacity");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_entry_total <= TOTAL_W'(CAP_TOT)))
        else $error("entry total above capacity");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
            && $stable(out_entry_total)))
        else $error("stalled result changed");

endmodule

bind hash_set_table hst_checker #(.CAPACITY(CAPACITY)) u_hst_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (request.valid),
    .in_ready        (request.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_status      (result.status),
    .out_entry_total (result.entry_total)
);

`default_nettype wire

[tb/hash_set_tracker.sv]
`timescale 1ns / 1ps

module hash_set_tracker
    import hst_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    hst_req_if        req,
    hst_res_if        res,
    output int        mismatch_total,
    output int        pending_results
);

    // Shadow copy of the stored hashes, kept packed below shadow_count.
    logic [HASH_W-1:0] shadow_table [CAPACITY];
    int                shadow_count;
    hst_result_t       expected_results [$];

    function automatic int locate_hash(input logic [HASH_W-1:0] key);
        int slot;
        slot = -1;
        for (int i = 0; i < shadow_count && i < CAPACITY; i++)
        begin
            if (slot < 0 && shadow_table[i] == key)
            begin
                slot = i;
            end
        end
        return slot;
    endfunction

    // Apply one command to the shadow set and return the result it must produce.
    function automatic hst_result_t apply_command(input logic [CMD_W-1:0]  op,
                                                  input logic [HASH_W-1:0] key);
        hst_result_t outcome;
        int          slot;
        slot = locate_hash(key);
        if (key == '0)
        begin
            outcome.status = ST_INVALID;
        end
        else if (op == CMD_INSERT)
        begin
            if (slot >= 0)
            begin
                outcome.status = ST_PRESENT;
            end
            else if (shadow_count >= CAPACITY)
            begin
                outcome.status = ST_FULL;
            end
            else
            begin
                shadow_table[shadow_count] = key;
                shadow_count++;
                outcome.status = ST_OK;
            end
        end
        else if (op == CMD_REMOVE)
        begin
            if (slot < 0)
            begin
                outcome.status = ST_MISSING;
            end
            else
            begin
                // move the last entry into the freed slot
                shadow_count--;
                shadow_table[slot] = shadow_table[shadow_count];
                shadow_table[shadow_count] = '0;
                outcome.status = ST_OK;
            end
        end
        else
        begin
            // lookup, and the spare selector behaves the same way
            outcome.status = (slot >= 0) ? ST_OK : ST_MISSING;
        end
        outcome.entry_total = TOTAL_W'(shadow_count);
        return outcome;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatch_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hst_result_t oldest;
        if (!rst_n)
        begin
            expected_results.delete();
            shadow_count    = 0;
            mismatch_total  = 0;
            pending_results = 0;
        end
        else
        begin
            // check the outgoing item first, so a result never meets its own request
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result item, status", res.status, -1);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (res.status !== oldest.status)
                    begin
                        report_mismatch("status", res.status, oldest.status);
                    end
                    if (res.entry_total !== oldest.entry_total)
                    begin
                        report_mismatch("entry_total", res.entry_total, oldest.entry_total);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_results.push_back(apply_command(req.cmd, req.device_hash));
            end
            pending_results = expected_results.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import hst_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int POOL_SIZE    = 96;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASE_COUNT  = 4;
    localparam int CYCLE_LIMIT  = 600000;

    // The block treats the spare selector value as a lookup.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   stall_pct;
    int   cycle_count;

    // Idle percentages per phase: none, sender only, receiver only, both.
    int send_idle_by_phase [PHASE_COUNT] = '{0, 58, 0, 17};
    int stall_by_phase     [PHASE_COUNT] = '{0, 0, 58, 17};

    // Keys are mostly drawn from a pool a bit larger than the table, so inserts
    // fill it up, hit the full case, and removes and lookups find real entries.
    logic [HASH_W-1:0] key_pool [POOL_SIZE];

    hst_req_if request_ch ();
    hst_res_if result_ch ();

    hash_set_table #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    hash_set_tracker #(
        .CAPACITY (CAPACITY)
    ) u_tracker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (request_ch),
        .res             (result_ch),
        .mismatch_total  (fail_count),
        .pending_results (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver: drop ready at random, at the rate the current phase asks.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [HASH_W-1:0] random_hash();
        return {$urandom, $urandom};
    endfunction

    // Offer one item and hold it until accepted. Valid stays high after the
    // accept so a back-to-back item never sees valid lowered and raised in one step.
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [HASH_W-1:0] key);
        if ($urandom_range(99) < send_idle_pct)
        begin
            request_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        request_ch.valid       <= 1'b1;
        request_ch.cmd         <= op;
        request_ch.device_hash <= key;
        do @(posedge clk); while (!request_ch.ready);
    endtask

    // Hold the sender off until every expected result has come back.
    task automatic wait_until_drained();
        request_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // One random item; the mix of inserts and removes tilts the table toward
    // full or toward empty.
    task automatic send_random_item(input int insert_pct, input int remove_pct);
        int                roll;
        logic [CMD_W-1:0]  op;
        logic [HASH_W-1:0] key;
        roll = $urandom_range(99);
        if (roll < insert_pct)
        begin
            op = CMD_INSERT;
        end
        else if (roll < insert_pct + remove_pct)
        begin
            op = CMD_REMOVE;
        end
        else if (roll < insert_pct + remove_pct + 5)
        begin
            op = CMD_SPARE;
        end
        else
        begin
            op = CMD_LOOKUP;
        end
        roll = $urandom_range(99);
        if (roll < 4)
        begin
            key = '0;
        end
        else if (roll < 88)
        begin
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
        end
        else
        begin
            key = random_hash();
        end
        send_item(op, key);
    endtask

    initial
    begin
        int item_index;
        int insert_pct;
        int remove_pct;

        rst_n       = 1'b0;
        cycle_count = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        request_ch.valid       <= 1'b0;
        request_ch.cmd         <= CMD_LOOKUP;
        request_ch.device_hash <= '0;

        // Seed the pool with the extreme keys, the rest random and nonzero.
        key_pool[0] = '1;
        key_pool[1] = 64'd1;
        key_pool[2] = {1'b1, 63'd0};
        for (int i = 3; i < POOL_SIZE; i++)
        begin
            key_pool[i] = random_hash() | 64'd1;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, zero hash with every selector, extreme keys,
        // duplicates, misses, and swap-removes from the front and the back.
        send_item(CMD_LOOKUP, key_pool[3]);
        send_item(CMD_REMOVE, key_pool[3]);
        send_item(CMD_LOOKUP, '0);
        send_item(CMD_INSERT, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_SPARE,  '0);
        send_item(CMD_INSERT, key_pool[0]);
        send_item(CMD_INSERT, key_pool[1]);
        send_item(CMD_INSERT, key_pool[2]);
        send_item(CMD_INSERT, key_pool[3]);
        send_item(CMD_INSERT, key_pool[0]);
        send_item(CMD_LOOKUP, key_pool[1]);
        send_item(CMD_SPARE,  key_pool[2]);
        send_item(CMD_SPARE,  key_pool[4]);
        send_item(CMD_REMOVE, key_pool[4]);
        send_item(CMD_REMOVE, key_pool[0]);
        send_item(CMD_LOOKUP, key_pool[3]);
        send_item(CMD_LOOKUP, key_pool[0]);
        send_item(CMD_REMOVE, key_pool[2]);
        send_item(CMD_REMOVE, key_pool[3]);
        send_item(CMD_REMOVE, key_pool[1]);
        send_item(CMD_LOOKUP, key_pool[1]);
        wait_until_drained();

        // Random part: one idling setting per phase, drain between phases.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            send_idle_pct = send_idle_by_phase[phase];
            stall_pct     = stall_by_phase[phase];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                item_index = phase * PHASE_ITEMS + n;
                if (item_index < 150 || (item_index >= 250 && item_index < 350))
                begin
                    insert_pct = 75;
                    remove_pct = 8;
                end
                else if (item_index < 250)
                begin
                    insert_pct = 15;
                    remove_pct = 65;
                end
                else
                begin
                    insert_pct = 35;
                    remove_pct = 35;
                end
                send_random_item(insert_pct, remove_pct);
            end
            wait_until_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (CAPACITY + 8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/hst_pkg.sv
rtl/hst_if.sv
rtl/hst_out_stage.sv
rtl/hash_set_table.sv
rtl/hst_checker.sv
tb/hash_set_tracker.sv
tb/testbench.sv
